### rtl/core/vstk_pkg.sv
// ----------------------------------------------------------------------------
// vstk_pkg
// Shared types and codes for the value stack: request and response payloads,
// operation and status codes, and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package vstk_pkg;

    // Field widths of the request and response payloads
    localparam int VAL_W    = 64;
    localparam int ARG_W    = 7;
    localparam int CMD_W    = 2;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADARG   = 2'd2;

    // Move engine modes
    localparam logic [1:0] MODE_DROP = 2'd0;  // store to store, closing the gap
    localparam logic [1:0] MODE_ROTA = 2'd1;  // store window to scratch, rotated
    localparam logic [1:0] MODE_ROTB = 2'd2;  // scratch back to store window

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] push_value;
        logic [ARG_W-1:0] count;
        logic [ARG_W-1:0] offset;
    } t_in_req;

    typedef struct packed {
        logic [VAL_W-1:0]    top_value;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } t_out_rsp;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       check;
        logic       push_wr;
        logic       dup_wr;
        logic       pass_start;
        logic       run;
        logic [1:0] mode;
        logic       drop_commit;
        logic       fetch;
        logic       top_load;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
        logic             ovf;
        logic             nop;
        logic             move_done;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/vstk_ram.sv
// ----------------------------------------------------------------------------
// vstk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vstk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/vstk_ctrl.sv
// ----------------------------------------------------------------------------
// vstk_ctrl
// Controller for the value stack: sequences check, write, move passes, top
// fetch and response for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module vstk_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire vstk_pkg::t_dp_stat  i_stat,
    output      vstk_pkg::t_ctl_cmd  o_cmd
);
    import vstk_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DUP_WR = 4'd2;
    localparam logic [3:0] S_DROP   = 4'd3;
    localparam logic [3:0] S_ROTA   = 4'd4;
    localparam logic [3:0] S_ROTB   = 4'd5;
    localparam logic [3:0] S_FETCH  = 4'd6;
    localparam logic [3:0] S_FWAIT  = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.bad || i_stat.ovf || i_stat.nop) begin
                    n_state = S_RESP;
                end else begin
                    case (i_stat.cmd)
                        CMD_PUSH: begin
                            o_cmd.push_wr = 1'b1;
                            n_state       = S_RESP;
                        end
                        CMD_DUP: begin
                            n_state = S_DUP_WR;
                        end
                        CMD_DROP: begin
                            o_cmd.pass_start = 1'b1;
                            n_state          = S_DROP;
                        end
                        default: begin
                            o_cmd.pass_start = 1'b1;
                            n_state          = S_ROTA;
                        end
                    endcase
                end
            end
            S_DUP_WR: begin
                o_cmd.dup_wr = 1'b1;
                n_state      = S_RESP;
            end
            S_DROP: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = MODE_DROP;
                if (i_stat.move_done) begin
                    o_cmd.drop_commit = 1'b1;
                    n_state           = S_FETCH;
                end
            end
            S_ROTA: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = MODE_ROTA;
                if (i_stat.move_done) begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_ROTB;
                end
            end
            S_ROTB: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = MODE_ROTB;
                if (i_stat.move_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_FWAIT;
            end
            S_FWAIT: begin
                o_cmd.top_load = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/core/vstk_dpath.sv
// ----------------------------------------------------------------------------
// vstk_dpath
// Datapath for the value stack: request register, depth and top registers,
// argument checks, the stack and scratch memories and the element move engine.
// ----------------------------------------------------------------------------
`default_nettype none

module vstk_dpath #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vstk_pkg::t_in_req   i_req,
    input  wire vstk_pkg::t_ctl_cmd  i_cmd,
    output      vstk_pkg::t_dp_stat  o_stat,
    output      vstk_pkg::t_out_rsp  o_rsp
);
    import vstk_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = ((DW > ARG_W) ? DW : ARG_W) + 1;

    t_in_req             r_req;
    logic [DW-1:0]       r_depth;
    logic [VAL_W-1:0]    r_top;
    logic [STATUS_W-1:0] r_status;
    logic [ARG_W-1:0]    r_i;
    logic [ARG_W-1:0]    r_j;
    logic [ARG_W-1:0]    r_len;
    logic                r_pend;
    logic [AW-1:0]       r_wa;

    logic [CW-1:0]    dep_e;
    logic [CW-1:0]    cnt_e;
    logic [CW-1:0]    off_e;
    logic [CW-1:0]    i_e;
    logic [CW-1:0]    j_e;
    logic             issue;
    logic [ARG_W-1:0] j_next;
    logic [AW-1:0]    wa_next;

    logic             st_we;
    logic [AW-1:0]    st_waddr;
    logic [VAL_W-1:0] st_wdata;
    logic [AW-1:0]    st_raddr;
    logic [VAL_W-1:0] st_rdata;
    logic             sc_we;
    logic [AW-1:0]    sc_raddr;
    logic [VAL_W-1:0] sc_rdata;

    assign dep_e = CW'(r_depth);
    assign cnt_e = CW'(r_req.count);
    assign off_e = CW'(r_req.offset);
    assign i_e   = CW'(r_i);
    assign j_e   = CW'(r_j);

    // Argument and capacity checks on the held request
    always_comb begin
        o_stat.cmd       = r_req.cmd;
        o_stat.bad       = 1'b0;
        o_stat.ovf       = 1'b0;
        o_stat.nop       = 1'b0;
        o_stat.move_done = (r_i == r_len) && !r_pend;
        case (r_req.cmd)
            CMD_PUSH: begin
                o_stat.ovf = dep_e >= CW'(STACK_DEPTH);
            end
            CMD_DUP: begin
                o_stat.bad = (cnt_e == '0) || (cnt_e > dep_e);
                o_stat.ovf = dep_e >= CW'(STACK_DEPTH);
            end
            CMD_DROP: begin
                o_stat.bad = (off_e + cnt_e) > dep_e;
                o_stat.nop = cnt_e == '0;
            end
            default: begin
                o_stat.bad = (cnt_e > dep_e) || (off_e > cnt_e);
                o_stat.nop = (off_e == '0) || (off_e == cnt_e);
            end
        endcase
    end

    // Move engine: one read issued per cycle, its write in the cycle after
    assign issue  = i_cmd.run && (r_i != r_len);
    assign j_next = ((j_e + CW'(1)) == cnt_e) ? '0 : (r_j + 1'b1);

    always_comb begin
        case (i_cmd.mode)
            MODE_DROP: wa_next = AW'(dep_e - off_e - cnt_e + i_e);
            MODE_ROTA: wa_next = AW'(i_e);
            MODE_ROTB: wa_next = AW'(dep_e - cnt_e + i_e);
            default:   wa_next = AW'(i_e);
        endcase
    end

    // Stack read address: top fetch, move source, or the dup source
    always_comb begin
        if (i_cmd.fetch) begin
            st_raddr = AW'(dep_e - CW'(1));
        end else if (i_cmd.run && (i_cmd.mode == MODE_DROP)) begin
            st_raddr = AW'(dep_e - off_e + i_e);
        end else if (i_cmd.run && (i_cmd.mode == MODE_ROTA)) begin
            st_raddr = AW'(dep_e - cnt_e + j_e);
        end else begin
            st_raddr = AW'(dep_e - cnt_e);
        end
    end

    // Stack write port
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_wa;
        st_wdata = st_rdata;
        if (i_cmd.push_wr) begin
            st_we    = 1'b1;
            st_waddr = AW'(dep_e);
            st_wdata = r_req.push_value;
        end else if (i_cmd.dup_wr) begin
            st_we    = 1'b1;
            st_waddr = AW'(dep_e);
        end else if (i_cmd.run && r_pend && (i_cmd.mode == MODE_DROP)) begin
            st_we = 1'b1;
        end else if (i_cmd.run && r_pend && (i_cmd.mode == MODE_ROTB)) begin
            st_we    = 1'b1;
            st_wdata = sc_rdata;
        end
    end

    // Scratch ports: rotated window in, then back out in order
    assign sc_we    = i_cmd.run && r_pend && (i_cmd.mode == MODE_ROTA);
    assign sc_raddr = AW'(i_e);

    vstk_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    vstk_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (r_wa),
        .i_wdata (st_rdata),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    // Hold the request and the result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.check) begin
            if (o_stat.bad) begin
                r_status <= ST_BADARG;
            end else if (o_stat.ovf) begin
                r_status <= ST_OVERFLOW;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    // Advance the move engine indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_j    <= '0;
            r_len  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.pass_start) begin
            r_i    <= '0;
            r_j    <= r_req.offset;
            r_len  <= (r_req.cmd == CMD_DROP) ? r_req.offset : r_req.count;
            r_pend <= 1'b0;
        end else if (i_cmd.run) begin
            r_pend <= issue;
            if (issue) begin
                r_i <= r_i + 1'b1;
                r_j <= j_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_wa <= wa_next;
        end
    end

    // Update depth and top of stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_top   <= '0;
        end else if (i_cmd.push_wr) begin
            r_depth <= r_depth + 1'b1;
            r_top   <= r_req.push_value;
        end else if (i_cmd.dup_wr) begin
            r_depth <= r_depth + 1'b1;
            r_top   <= st_rdata;
        end else if (i_cmd.drop_commit) begin
            r_depth <= DW'(dep_e - cnt_e);
        end else if (i_cmd.top_load) begin
            r_top <= (r_depth != '0) ? st_rdata : '0;
        end
    end

    // Drive the response
    always_comb begin
        o_rsp.top_value = r_top;
        o_rsp.depth     = DEPTH_W'(dep_e);
        o_rsp.status    = r_status;
    end

endmodule

`default_nettype wire

### rtl/core/value_stack_dup_drop_rotate.sv
// ----------------------------------------------------------------------------
// value_stack_dup_drop_rotate
// Value stack of 64-bit elements with push, dup, drop and rotate commands.
// ----------------------------------------------------------------------------
// One request is handled at a time and answered by exactly one response
// carrying the new top value (zero when empty), the depth and a status
// (ok, overflow, bad argument; a refused request leaves the stack as it was).
// Drop and rotate requests that move elements take longer than the others
// because of the element moves: the stack memory has one read and one
// write port, so drop moves one kept element per cycle and rotate copies
// the window into a scratch memory and back, one element per cycle each way.
// After the response is taken the block is ready again in the next cycle.
// Stack contents need no clearing after reset; the depth, the top value and
// the move engine indices are reset.
// ----------------------------------------------------------------------------
`default_nettype none

module value_stack_dup_drop_rotate #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire vstk_pkg::t_in_req  i_in_req,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      vstk_pkg::t_out_rsp o_out_rsp
);
    import vstk_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // Sequence each request
    vstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (ctl_cmd)
    );

    // Hold the stack and move its elements
    vstk_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (ctl_cmd),
        .o_stat  (dp_stat),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-bit value stack: a mirror of the stack
// predicts each response from the accepted requests, and a checker compares
// every response with the oldest prediction, field by field. Directed cases
// (empty and full stack, refused arguments, no-op moves) are followed by a
// long receiver hold-off and by random traffic steered towards varying depths.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vstk_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int MAX_REPORTS  = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_out_rsp out_rsp;

    // Mirror of the stack contents and depth, updated at each accepted request
    logic [VAL_W-1:0] mirror_mem [STACK_DEPTH];
    int               mirror_depth = 0;

    t_out_rsp answer_q [$];
    int       fail_count = 0;
    int       hold_asks  = 0;

    value_stack_dup_drop_rotate #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the mirror and return the response it must produce
    function automatic t_out_rsp apply_stack_op(t_in_req req);
        t_out_rsp         rsp;
        logic [VAL_W-1:0] window [STACK_DEPTH];
        int               cnt;
        int               off;
        int               base;
        int               src;
        cnt = int'(req.count);
        off = int'(req.offset);
        rsp.status = ST_OK;
        case (req.cmd)
            CMD_PUSH: begin
                if (mirror_depth >= STACK_DEPTH) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    mirror_mem[mirror_depth] = req.push_value;
                    mirror_depth++;
                end
            end
            CMD_DUP: begin
                // argument is checked before overflow
                if (cnt == 0 || cnt > mirror_depth) begin
                    rsp.status = ST_BADARG;
                end else if (mirror_depth >= STACK_DEPTH) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    mirror_mem[mirror_depth] = mirror_mem[mirror_depth - cnt];
                    mirror_depth++;
                end
            end
            CMD_DROP: begin
                if (off + cnt > mirror_depth) begin
                    rsp.status = ST_BADARG;
                end else begin
                    base = mirror_depth - off - cnt;
                    for (int i = 0; i < off; i++)
                        mirror_mem[base + i] = mirror_mem[base + cnt + i];
                    mirror_depth -= cnt;
                end
            end
            CMD_ROTATE: begin
                if (cnt > mirror_depth || off > cnt) begin
                    rsp.status = ST_BADARG;
                end else if (cnt > 0) begin
                    base = mirror_depth - cnt;
                    for (int i = 0; i < cnt; i++) begin
                        src = (i + off) % cnt;
                        window[i] = mirror_mem[base + src];
                    end
                    for (int i = 0; i < cnt; i++)
                        mirror_mem[base + i] = window[i];
                end
            end
        endcase
        rsp.top_value = (mirror_depth > 0) ? mirror_mem[mirror_depth - 1] : '0;
        rsp.depth     = DEPTH_W'(mirror_depth);
        return rsp;
    endfunction

    function automatic t_in_req build_req(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val,
                                          int cnt, int off);
        t_in_req r;
        r.cmd        = cmd;
        r.push_value = val;
        r.count      = ARG_W'(cnt);
        r.offset     = ARG_W'(off);
        return r;
    endfunction

    // Random request, mostly legal for the current depth, drifting towards target
    function automatic t_in_req make_request(int target);
        t_in_req r;
        int      d;
        int      pick;
        int      wpush;
        int      wdrop;
        int      cnt;
        int      off;
        d            = mirror_depth;
        r.cmd        = CMD_W'($urandom_range(0, 3));
        r.push_value = {$urandom, $urandom};
        r.count      = ARG_W'($urandom_range(0, 127));
        r.offset     = ARG_W'($urandom_range(0, 127));
        // a few requests stay fully random
        if ($urandom_range(0, 99) < 5)
            return r;
        wpush = (d < target) ? 45 : 10;
        wdrop = (d > target) ? 35 : 12;
        pick  = $urandom_range(0, wpush + wdrop + 40 - 1);
        if (pick < wpush) begin
            r.cmd = CMD_PUSH;
            case ($urandom_range(0, 9))
                0:       r.push_value = '0;
                1:       r.push_value = '1;
                default: ;
            endcase
        end else if (pick < wpush + 15) begin
            r.cmd = CMD_DUP;
            if (d == 0 || $urandom_range(0, 9) == 0)
                cnt = $urandom_range(0, 1) ? 0 : $urandom_range(d + 1, 127);
            else
                cnt = $urandom_range(1, d);
            r.count = ARG_W'(cnt);
        end else if (pick < wpush + 15 + wdrop) begin
            r.cmd = CMD_DROP;
            case ($urandom_range(0, 11))
                0: begin
                    // span reaches past the bottom
                    off = $urandom_range(0, 127);
                    cnt = $urandom_range((off > d) ? 0 : d + 1 - off, 127);
                end
                1: begin
                    cnt = $urandom_range(0, d);
                    off = $urandom_range(0, d - cnt);
                end
                default: begin
                    cnt = $urandom_range(0, (d < 4) ? d : 4);
                    off = $urandom_range(0, (d - cnt < 6) ? d - cnt : 6);
                end
            endcase
            r.count  = ARG_W'(cnt);
            r.offset = ARG_W'(off);
        end else begin
            r.cmd = CMD_ROTATE;
            case ($urandom_range(0, 11))
                0: begin
                    cnt = $urandom_range(d + 1, 127);
                    off = $urandom_range(0, 127);
                end
                1: begin
                    cnt = $urandom_range(0, d);
                    off = $urandom_range(cnt + 1, 127);
                end
                2: begin
                    cnt = $urandom_range(0, d);
                    off = $urandom_range(0, cnt);
                end
                default: begin
                    cnt = $urandom_range(0, (d < 8) ? d : 8);
                    off = $urandom_range(0, cnt);
                end
            endcase
            r.count  = ARG_W'(cnt);
            r.offset = ARG_W'(off);
        end
        return r;
    endfunction

    // Offer one request and hold it until accepted; valid stays high on return
    task automatic send_request(input t_in_req req);
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        answer_q.push_back(apply_stack_op(req));
    endtask

    // Drop valid for a number of cycles
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Compare each accepted response with the oldest prediction
    always @(posedge clk) begin : check_rsp
        t_out_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (answer_q.size() == 0) begin
                note_failure($sformatf("unexpected response top=%h depth=%0d status=%0d",
                                       out_rsp.top_value, out_rsp.depth, out_rsp.status));
            end else begin
                want = answer_q.pop_front();
                if (out_rsp.top_value !== want.top_value || out_rsp.depth !== want.depth ||
                    out_rsp.status !== want.status)
                    note_failure($sformatf(
                        "mismatch: top %h/%h depth %0d/%0d status %0d/%0d (expected/actual)",
                        want.top_value, out_rsp.top_value, want.depth, out_rsp.depth,
                        want.status, out_rsp.status));
            end
        end
    end

    // Drive the response ready: steady stretches, short stalls, and long hold-offs on request
    initial begin : rx_drive
        int   run_left;
        int   hold_left;
        int   holds_seen;
        logic level;
        run_left   = 0;
        hold_left  = 0;
        holds_seen = 0;
        level      = 1'b1;
        forever begin
            @(posedge clk);
            if (holds_seen != hold_asks) begin
                holds_seen = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            level    = 1'b1;
                            run_left = $urandom_range(20, 60);
                        end
                        1: begin
                            level    = 1'b0;
                            run_left = $urandom_range(1, 6);
                        end
                        default: begin
                            level    = ($urandom_range(0, 2) != 0);
                            run_left = $urandom_range(1, 4);
                        end
                    endcase
                end
                run_left--;
                out_ready <= level;
            end
        end
    end

    // Empty-stack refusals, pushes of extreme values, each command and its edge cases
    task automatic test_directed_ops;
        send_request(build_req(CMD_DROP,   '0, 0, 0));
        send_request(build_req(CMD_ROTATE, '0, 0, 0));
        send_request(build_req(CMD_DUP,    '0, 1, 0));
        send_request(build_req(CMD_ROTATE, '0, 1, 0));
        send_request(build_req(CMD_DROP,   '0, 1, 0));
        send_request(build_req(CMD_PUSH,   '0, 0, 0));
        send_request(build_req(CMD_PUSH,   '1, 0, 0));
        pause_sender(3);
        send_request(build_req(CMD_PUSH,   64'h8000_0000_0000_0001, 0, 0));
        send_request(build_req(CMD_PUSH,   64'h5555_aaaa_3333_cccc, 0, 0));
        send_request(build_req(CMD_DUP,    '1, 0, 0));
        send_request(build_req(CMD_DUP,    '0, 5, 0));
        send_request(build_req(CMD_DUP,    '0, 4, 0));
        send_request(build_req(CMD_DUP,    '0, 1, 0));
        send_request(build_req(CMD_ROTATE, '0, 4, 1));
        send_request(build_req(CMD_ROTATE, '0, 4, 3));
        send_request(build_req(CMD_ROTATE, '0, 4, 5));
        send_request(build_req(CMD_ROTATE, '0, 4, 4));
        pause_sender(1);
        send_request(build_req(CMD_ROTATE, '0, 4, 0));
        send_request(build_req(CMD_DROP,   '0, 2, 2));
        send_request(build_req(CMD_DROP,   '0, 0, 3));
        send_request(build_req(CMD_DROP,   '0, 3, 2));
        send_request(build_req(CMD_DROP,   '0, 127, 127));
        send_request(build_req(CMD_ROTATE, '0, 127, 127));
        send_request(build_req(CMD_DUP,    '0, 127, 0));
        send_request(build_req(CMD_PUSH,   64'h0123_4567_89ab_cdef, 127, 127));
        pause_sender(2);
    endtask

    // Fill to capacity, hit overflow, move the whole stack, then empty it
    task automatic test_full_stack;
        while (mirror_depth < STACK_DEPTH)
            send_request(build_req(CMD_PUSH, {$urandom, $urandom}, 0, 0));
        send_request(build_req(CMD_PUSH,   '1, 0, 0));
        send_request(build_req(CMD_DUP,    '0, 1, 0));
        send_request(build_req(CMD_DUP,    '0, 0, 0));
        send_request(build_req(CMD_DUP,    '0, STACK_DEPTH + 1, 0));
        send_request(build_req(CMD_DUP,    '0, STACK_DEPTH, 0));
        send_request(build_req(CMD_ROTATE, '0, STACK_DEPTH, 1));
        send_request(build_req(CMD_ROTATE, '0, STACK_DEPTH, STACK_DEPTH - 1));
        send_request(build_req(CMD_ROTATE, '0, STACK_DEPTH, STACK_DEPTH));
        send_request(build_req(CMD_ROTATE, '0, STACK_DEPTH + 1, 0));
        send_request(build_req(CMD_DROP,   '0, 1, STACK_DEPTH - 1));
        send_request(build_req(CMD_DROP,   '0, 2, STACK_DEPTH - 1));
        send_request(build_req(CMD_PUSH,   {$urandom, $urandom}, 0, 0));
        send_request(build_req(CMD_DROP,   '0, STACK_DEPTH, 0));
        send_request(build_req(CMD_DUP,    '0, 1, 0));
        pause_sender(4);
    endtask

    // Hold the response side off for a long stretch while requests keep coming
    task automatic test_receiver_hold_off;
        hold_asks++;
        repeat (12)
            send_request(make_request(STACK_DEPTH));
        pause_sender(5);
    endtask

    // Random bursts with random gaps, the target depth wandering over the range
    task automatic test_random_traffic;
        int sent;
        int target;
        int next_retarget;
        int steady_left;
        sent          = 0;
        target        = STACK_DEPTH / 2;
        next_retarget = 0;
        steady_left   = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_retarget) begin
                target        = $urandom_range(0, STACK_DEPTH);
                next_retarget = sent + $urandom_range(30, 120);
            end
            repeat ($urandom_range(1, 12)) begin
                send_request(make_request(target));
                sent++;
            end
            // now and then run several bursts back to back
            if (steady_left > 0)
                steady_left--;
            else if ($urandom_range(0, 19) == 0)
                steady_left = $urandom_range(5, 15);
            else
                pause_sender($urandom_range(0, 8));
        end
        pause_sender(1);
    endtask

    // Wait for outstanding responses, then a quiet spell to catch strays
    task automatic wait_for_drain;
        int waited;
        waited = 0;
        while (answer_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (answer_q.size() != 0)
            note_failure($sformatf("%0d responses never arrived", answer_q.size()));
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_ops();
        test_full_stack();
        test_receiver_hold_off();
        test_random_traffic();
        wait_for_drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
